[sv/msbt_pkg.sv]
// ----------------------------------------------------------------------------
// msbt_pkg
// Shared sizes and record type for the timestamp merge sorter.
// ----------------------------------------------------------------------------
package msbt_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int KEY_W     = 32;
    localparam int ID_W      = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  item_id;
    } record_t;

endpackage

[sv/msbt_if.sv]
// ----------------------------------------------------------------------------
// msbt_in_if / msbt_out_if
// Valid/ready channels for input records and sorted results.
// ----------------------------------------------------------------------------
interface msbt_in_if
    import msbt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  item_id;
    logic             last;

    modport source (output valid, output key, output item_id, output last, input ready);
    modport sink   (input valid, input key, input item_id, input last, output ready);
endinterface

interface msbt_out_if
    import msbt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_res;
    logic [ID_W-1:0]  item_id_res;
    logic             last_res;
    logic             overflowed;

    modport source (output valid, output key_res, output item_id_res, output last_res,
                    output overflowed, input ready);
    modport sink   (input valid, input key_res, input item_id_res, input last_res,
                    input overflowed, output ready);
endinterface

[sv/msbt_ram_bank.sv]
// ----------------------------------------------------------------------------
// msbt_ram_bank
// Record store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module msbt_ram_bank
    import msbt_pkg::*;
(
    input  logic    clk,
    input  logic    we,
    input  idx_t    waddr,
    input  record_t wdata,
    input  idx_t    raddr_a,
    input  idx_t    raddr_b,
    output record_t rdata_a,
    output record_t rdata_b
);

    record_t mem [MAX_ITEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[sv/merge_sort_by_timestamp_core.sv]
// Loading: one record per cycle while idle; ready stays low from the last record until the
//   final sorted record is transferred.
// Sorting: ceil(log2 N) passes over two ping-pong banks; each merge step is a registered memory
//   read, then compare and write, with a setup state before each merged run.
// Emitting: each record is read, loaded into the output register, then held until the sink takes it.
// Reset (async, active low) empties the store and returns to loading; no clearing pass.
// ----------------------------------------------------------------------------
// merge_sort_by_timestamp_core
// Collects up to MAX_ITEMS records until last, merge-sorts them by key, emits them in order.
// ----------------------------------------------------------------------------
module merge_sort_by_timestamp_core
    import msbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    msbt_in_if.sink     in_ch,
    msbt_out_if.source  out_ch
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_HOLD
    } state_t;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    logic    ovf_reg, ovf_next;
    cnt_t    n_reg, n_next;
    cnt_t    width_reg, width_next;
    cnt_t    lo_reg, lo_next;
    cnt_t    mid_reg, mid_next;
    cnt_t    hi_reg, hi_next;
    cnt_t    i_reg, i_next;
    cnt_t    j_reg, j_next;
    cnt_t    k_reg, k_next;
    logic    src_reg, src_next;
    logic    out_valid_reg, out_valid_next;
    record_t out_rec_reg, out_rec_next;
    logic    out_last_reg, out_last_next;

    logic    in_accept;
    logic    store_in;
    logic    mrg_we;
    logic    take_left;
    logic    we0, we1;
    idx_t    waddr;
    record_t wdata;
    record_t rd0_a, rd0_b, rd1_a, rd1_b;
    record_t rd_a, rd_b;
    logic [CNT_W:0] sum_mid, sum_hi;
    cnt_t    count_inc;
    cnt_t    width_dbl;

    msbt_ram_bank u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (i_reg[IDX_W-1:0]),
        .raddr_b (j_reg[IDX_W-1:0]),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    msbt_ram_bank u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (i_reg[IDX_W-1:0]),
        .raddr_b (j_reg[IDX_W-1:0]),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    assign rd_a = src_reg ? rd1_a : rd0_a;
    assign rd_b = src_reg ? rd1_b : rd0_b;

    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_accept   = in_ch.valid && (state_reg == ST_LOAD);
    assign store_in    = in_accept && (count_reg < CNT_W'(MAX_ITEMS));
    assign count_inc   = count_reg + CNT_W'(1);

    assign take_left = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (rd_a.key < rd_b.key));
    assign mrg_we    = (state_reg == ST_MRG_WR);

    assign we0   = store_in || (mrg_we && src_reg);
    assign we1   = mrg_we && !src_reg;
    assign waddr = mrg_we ? k_reg[IDX_W-1:0] : count_reg[IDX_W-1:0];
    assign wdata = mrg_we ? (take_left ? rd_a : rd_b)
                          : record_t'{key: in_ch.key, item_id: in_ch.item_id};

    assign sum_mid   = {1'b0, lo_reg} + {1'b0, width_reg};
    assign sum_hi    = sum_mid + {1'b0, width_reg};
    assign width_dbl = {width_reg[CNT_W-2:0], 1'b0};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_in)
                    begin
                        count_next = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_ch.last)
                    begin
                        n_next     = store_in ? count_inc : count_reg;
                        src_next   = 1'b0;
                        width_next = CNT_W'(1);
                        lo_next    = '0;
                        i_next     = '0;
                        state_next = (n_next == CNT_W'(1)) ? ST_EMIT_RD : ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                mid_next   = (sum_mid > {1'b0, n_reg}) ? n_reg : sum_mid[CNT_W-1:0];
                hi_next    = (sum_hi > {1'b0, n_reg}) ? n_reg : sum_hi[CNT_W-1:0];
                i_next     = lo_reg;
                j_next     = mid_next;
                k_next     = lo_reg;
                state_next = ST_MRG_RD;
            end
            ST_MRG_RD:
            begin
                state_next = ST_MRG_WR;
            end
            ST_MRG_WR:
            begin
                if (take_left)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                k_next = k_reg + CNT_W'(1);
                if (k_next == hi_reg)
                begin
                    if (hi_reg == n_reg)
                    begin
                        src_next   = !src_reg;
                        width_next = width_dbl;
                        lo_next    = '0;
                        if (width_dbl >= n_reg)
                        begin
                            i_next     = '0;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                    else
                    begin
                        lo_next    = hi_reg;
                        state_next = ST_SETUP;
                    end
                end
                else
                begin
                    state_next = ST_MRG_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_rec_next   = rd_a;
                out_last_next  = ((i_reg + CNT_W'(1)) == n_reg);
                out_valid_next = 1'b1;
                state_next     = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD:
            begin
                if (out_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            width_reg     <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_rec_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
            out_rec_reg   <= out_rec_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.key_res     = out_rec_reg.key;
    assign out_ch.item_id_res = out_rec_reg.item_id;
    assign out_ch.last_res    = out_last_reg;
    assign out_ch.overflowed  = ovf_reg;

endmodule

[sv/msbt_checker.sv]
// ----------------------------------------------------------------------------
// msbt_checker
// Port-level checks on the timestamp merge sorter, bound to the top level.
// ----------------------------------------------------------------------------
module msbt_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_last_res
);

    // held result until transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while a result is pending");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input ready right after the set was closed");

    a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last_res |=> !out_valid && in_ready)
        else $error("block not back to loading after the final transfer");

endmodule

bind merge_sort_by_timestamp_core msbt_checker u_msbt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_last      (in_ch.last),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_last_res (out_ch.last_res)
);
